/* hdl/pic_pkg.sv */
`timescale 1ns / 1ps

package pic_pkg;

  localparam int NUM_SOURCES = 32;
  localparam logic [31:0] SRC_MASK = 32'hFFFF_FFFF >> (32 - NUM_SOURCES);

  // Request kinds carried on tuser.
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  // Word indexes of the register map.
  localparam logic [6:0] REG_STATUS     = 7'd0;
  localparam logic [6:0] REG_PENDING    = 7'd1;
  localparam logic [6:0] REG_ENABLE     = 7'd2;
  localparam logic [6:0] REG_ACK        = 7'd3;
  localparam logic [6:0] REG_SET_ENABLE = 7'd4;
  localparam logic [6:0] REG_CLR_ENABLE = 7'd5;
  localparam logic [6:0] REG_VECTOR     = 7'd6;
  localparam logic [6:0] REG_MASTER     = 7'd7;
  localparam logic [6:0] REG_TABLE_LO   = 7'd64;
  localparam logic [6:0] REG_TABLE_HI   = 7'd95;

  localparam int TABLE_DEPTH = 32;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

  localparam logic [31:0] NO_VECTOR = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] irq_lines;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
  } result_t;

  // Index of the lowest set bit. The lowest bit is isolated first, so each
  // output bit is a plain OR over the one-hot word.
  function automatic logic [4:0] lowest_index(input logic [31:0] p);
    logic [31:0] iso;
    logic [4:0]  idx;
    iso = p & (~p + 32'd1);
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      idx = idx | ({5{iso[i]}} & 5'(i));
    end
    return idx;
  endfunction

endpackage

/* hdl/pic_core.sv */
`timescale 1ns / 1ps

module pic_core
  import pic_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  item_t   item,
  output result_t result
);

  logic [31:0] status_r, status_nxt;
  logic [31:0] enable_r, enable_nxt;
  logic        master_r, master_nxt;
  logic        hw_en_r, hw_en_nxt;

  logic [31:0]            vt_data_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vt_valid_r;

  logic [TABLE_AW-1:0] vt_sel;
  logic                vt_we;
  logic [31:0]         vt_rd;
  logic [31:0]         pending;
  logic [31:0]         rd;

  assign vt_sel  = item.reg_index[TABLE_AW-1:0];
  // Entries never written since reset read as zero.
  assign vt_rd   = vt_valid_r[vt_sel] ? vt_data_r[vt_sel] : 32'd0;
  assign pending = status_r & enable_r & SRC_MASK;

  always_comb begin
    status_nxt = status_r;
    enable_nxt = enable_r;
    master_nxt = master_r;
    hw_en_nxt  = hw_en_r;
    vt_we      = 1'b0;
    rd         = 32'd0;
    unique case (item.req_type)
      REQ_READ: begin
        unique case (item.reg_index) inside
          REG_STATUS:  rd = status_r;
          REG_PENDING: rd = status_r & enable_r;
          REG_ENABLE:  rd = enable_r;
          REG_VECTOR:  rd = (pending == 32'd0) ? NO_VECTOR
                                               : {27'd0, lowest_index(pending)};
          REG_MASTER:  rd = {30'd0, hw_en_r, master_r};
          [REG_TABLE_LO:REG_TABLE_HI]: rd = vt_rd;
          default:     rd = 32'd0;
        endcase
      end
      REQ_WRITE: begin
        unique case (item.reg_index) inside
          REG_STATUS: begin
            if (!hw_en_r) begin
              status_nxt = status_r | (item.write_data & SRC_MASK);
            end
          end
          REG_ENABLE:     enable_nxt = item.write_data & SRC_MASK;
          REG_ACK:        status_nxt = status_r & ~item.write_data;
          REG_SET_ENABLE: enable_nxt = enable_r | (item.write_data & SRC_MASK);
          REG_CLR_ENABLE: enable_nxt = enable_r & ~item.write_data;
          REG_MASTER: begin
            master_nxt = item.write_data[0];
            // Hardware enable can only be set; reset alone clears it.
            hw_en_nxt  = hw_en_r | item.write_data[1];
          end
          [REG_TABLE_LO:REG_TABLE_HI]: vt_we = 1'b1;
          default: ;
        endcase
      end
      REQ_SAMPLE: begin
        if (hw_en_r) begin
          status_nxt = status_r | (item.irq_lines & SRC_MASK);
        end
      end
      default: ;
    endcase
  end

  assign result.read_data   = rd;
  assign result.irq_request = master_nxt && ((status_nxt & enable_nxt & SRC_MASK) != 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= '0;
      enable_r   <= '0;
      master_r   <= 1'b0;
      hw_en_r    <= 1'b0;
      vt_valid_r <= '0;
    end else if (adv) begin
      status_r <= status_nxt;
      enable_r <= enable_nxt;
      master_r <= master_nxt;
      hw_en_r  <= hw_en_nxt;
      if (vt_we) begin
        vt_valid_r[vt_sel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vt_we) begin
      vt_data_r[vt_sel] <= item.write_data;
    end
  end

endmodule

/* hdl/priority_interrupt_controller.sv */
`timescale 1ns / 1ps
// Path: an accepted request is held in the input register, and its response is
// captured in the response register once that register is free.
// Throughput: one request per cycle unless out_tready stalls it; the
// register update and the 32-bit priority encode both sit between the input and
// response registers. Reset: status, enable, master and hardware enable clear,
// the vector table reads all zeros, and both register stages come up empty.

module priority_interrupt_controller
  import pic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] reg_index, [38:7] write_data, [70:39] irq_lines, [71] zero
  input  logic [71:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] read_data, [32] irq_request, [39:33] zero
  output logic [39:0] out_tdata
);

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t core_res;
  logic    adv;

  // The held request is processed when the response register is free.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.req_type   <= in_tuser;
      in_item_r.reg_index  <= in_tdata[6:0];
      in_item_r.write_data <= in_tdata[38:7];
      in_item_r.irq_lines  <= in_tdata[70:39];
    end
    if (adv) begin
      out_res_r <= core_res;
    end
  end

  pic_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (in_item_r),
    .result (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.irq_request, out_res_r.read_data};

endmodule
